FILE: sv/vpi_pkg.sv
// ----------------------------------------------------------------------------
// Verlet position integrator package
// Shared widths, codes, lane control and result types, and word saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package vpi_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ATOM_W      = 10;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned IN_TDATA_W  = 304;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned SAT_IN_W    = 64;

  // Stages from the registered request to the output register.
  localparam int unsigned PIPE_STAGES = 5;
  localparam int unsigned LANE_STAGES = PIPE_STAGES - 1;

  localparam logic [DATA_W-1:0] TIME_STEP_RST     = 32'd655;
  localparam logic [DATA_W-1:0] TIME_STEP_SQ_RST  = 32'd7;
  localparam logic [DATA_W-1:0] INV_TWO_STEPS_RST = 32'd3276800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = 2'd0,
    CFG_TIME_STEP_SQ  = 2'd1,
    CFG_INV_TWO_STEPS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic                   step;
    logic [LANE_STAGES-1:0] load;
  } lane_ctrl_t;

  typedef struct packed {
    word_t pos;
    word_t vel;
    word_t prev_wr;
    word_t ahead_wr;
    logic  sat;
  } lane_res_t;

  typedef struct packed {
    word_t value;
    logic  flag;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SAT_IN_W-1:0] x);
    sat_t r;
    if ((x[SAT_IN_W-1:DATA_W-1] == '0) || (x[SAT_IN_W-1:DATA_W-1] == '1)) begin
      r.value = x[DATA_W-1:0];
      r.flag  = 1'b0;
    end else if (x[SAT_IN_W-1]) begin
      r.value = {1'b1, {(DATA_W-1){1'b0}}};
      r.flag  = 1'b1;
    end else begin
      r.value = {1'b0, {(DATA_W-1){1'b1}}};
      r.flag  = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/verlet_position_integrator.sv
// ----------------------------------------------------------------------------
// Verlet position integrator
// Per-atom position Verlet for three axes with stored previous and ahead
// positions in two memories, one row of three axes per atom.
// ----------------------------------------------------------------------------
// A result reaches the master side through the pipeline stages and the output
// register. Throughput: one request per cycle while the output is not stalled and
// the atom differs from those of the five requests still in the pipeline; a
// repeated atom waits until the older request has written its row back.
// Reset clears the pipeline valid flags, the output valid flag and restores the
// configuration registers; the atom memories are not cleared.
`default_nettype none

module verlet_position_integrator #(
  parameter int unsigned MAX_ATOMS     = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // atom_index, position_x/y/z, velocity_x/y/z, force_x/y/z, zero pad
  input  logic [vpi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // new_position_x/y/z, new_velocity_x/y/z
  output logic [vpi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [vpi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vpi_pkg::DATA_W-1:0]        cfg_data_i
);

  import vpi_pkg::*;

  localparam int unsigned AW     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned ROW_W  = NUM_AXES * DATA_W;
  localparam int unsigned FLD_W  = 3 * ROW_W;

  // Configuration registers.
  logic [DATA_W-1:0] time_step_q, time_step_sq_q, inv_two_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q     <= TIME_STEP_RST;
      time_step_sq_q  <= TIME_STEP_SQ_RST;
      inv_two_steps_q <= INV_TWO_STEPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TIME_STEP:     time_step_q     <= cfg_data_i;
        CFG_TIME_STEP_SQ:  time_step_sq_q  <= cfg_data_i;
        CFG_INV_TWO_STEPS: inv_two_steps_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Atom index wrapped into the memory depth.
  logic [ATOM_W-1:0] in_atom_raw;
  logic [AW-1:0]     in_atom;

  assign in_atom_raw = s_axis_tdata[ATOM_W-1:0];

  if (MAX_ATOMS == 1) begin : g_wrap_one
    assign in_atom = '0;
  end else if (MAX_ATOMS >= (1 << ATOM_W)) begin : g_wrap_none
    assign in_atom = AW'(in_atom_raw);
  end else if ((MAX_ATOMS & (MAX_ATOMS - 1)) == 0) begin : g_wrap_mask
    assign in_atom = in_atom_raw[AW-1:0];
  end else begin : g_wrap_recip
    localparam int unsigned WRAP_SH = 2 * ATOM_W;
    localparam logic [WRAP_SH-1:0] RECIP =
      WRAP_SH'(((1 << WRAP_SH) + MAX_ATOMS - 1) / MAX_ATOMS);
    localparam logic [ATOM_W+1:0] MOD_C = (ATOM_W + 2)'(MAX_ATOMS);
    logic [ATOM_W+WRAP_SH-1:0] quo_prod;
    logic [ATOM_W-1:0]         quo;
    logic [ATOM_W+1:0]         rem, rem_fix;
    // The reciprocal quotient is exact or one too large.
    always_comb begin
      quo_prod = in_atom_raw * RECIP;
      quo      = quo_prod[ATOM_W+WRAP_SH-1:WRAP_SH];
      rem      = {2'b00, in_atom_raw} - ((ATOM_W + 2)'(quo) * MOD_C);
      rem_fix  = rem[ATOM_W+1] ? (rem + MOD_C) : rem;
    end
    assign in_atom = rem_fix[AW-1:0];
  end

  // Flow control: each stage loads when it is empty or its successor loads.
  logic [PIPE_STAGES:1]   v_q;
  logic [PIPE_STAGES+1:1] rdy;
  logic                   out_valid_q;
  logic                   ready_out;
  logic                   hazard;
  logic                   accept;
  logic                   mem_we;
  logic [AW-1:0]          atom_q [1:PIPE_STAGES];

  assign ready_out = !out_valid_q || m_axis_tready;

  always_comb begin
    rdy[PIPE_STAGES+1] = ready_out;
    for (int k = PIPE_STAGES; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= PIPE_STAGES; k++) begin
      if (v_q[k] && (atom_q[k] == in_atom)) begin
        hazard = 1'b1;
      end
    end
  end

  assign s_axis_tready = rdy[1] && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = v_q[PIPE_STAGES] && ready_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= accept;
      end
      for (int k = 2; k <= PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (ready_out) begin
        out_valid_q <= v_q[PIPE_STAGES];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      atom_q[1] <= in_atom;
    end
    for (int k = 2; k <= PIPE_STAGES; k++) begin
      if (rdy[k]) begin
        atom_q[k] <= atom_q[k-1];
      end
    end
  end

  // Registered request fields.
  cmd_e             cmd1_q;
  logic [FLD_W-1:0] fields1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      cmd1_q    <= cmd_e'(s_axis_tuser);
      fields1_q <= s_axis_tdata[ATOM_W +: FLD_W];
    end
  end

  // Atom state memories.
  logic [ROW_W-1:0] prev_mem  [MAX_ATOMS];
  logic [ROW_W-1:0] ahead_mem [MAX_ATOMS];
  logic [ROW_W-1:0] prev_rd_q, ahead_rd_q;
  logic [ROW_W-1:0] prev_wr, ahead_wr;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_rd_q  <= prev_mem[in_atom];
      ahead_rd_q <= ahead_mem[in_atom];
    end
    if (mem_we) begin
      prev_mem[atom_q[PIPE_STAGES]]  <= prev_wr;
      ahead_mem[atom_q[PIPE_STAGES]] <= ahead_wr;
    end
  end

  // Axis lanes.
  lane_ctrl_t lane_ctrl;
  lane_res_t  lane_res [NUM_AXES];

  assign lane_ctrl.step = (cmd1_q == CMD_STEP);
  assign lane_ctrl.load = rdy[PIPE_STAGES:2];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    vpi_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk_i           (clk_i),
      .ctrl_i          (lane_ctrl),
      .pos_i           (fields1_q[k*DATA_W +: DATA_W]),
      .vel_i           (fields1_q[(NUM_AXES+k)*DATA_W +: DATA_W]),
      .force_i         (fields1_q[(2*NUM_AXES+k)*DATA_W +: DATA_W]),
      .prev_i          (prev_rd_q[k*DATA_W +: DATA_W]),
      .ahead_i         (ahead_rd_q[k*DATA_W +: DATA_W]),
      .time_step_i     (time_step_q),
      .time_step_sq_i  (time_step_sq_q),
      .inv_two_steps_i (inv_two_steps_q),
      .res_o           (lane_res[k])
    );
    assign prev_wr[k*DATA_W +: DATA_W]  = lane_res[k].prev_wr;
    assign ahead_wr[k*DATA_W +: DATA_W] = lane_res[k].ahead_wr;
  end

  // Output register.
  logic [OUT_TDATA_W-1:0] out_data_d, out_data_q;
  logic                   out_sat_d, out_sat_q;

  always_comb begin
    out_data_d = '0;
    out_sat_d  = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      out_data_d[k*DATA_W +: DATA_W]            = lane_res[k].pos;
      out_data_d[(NUM_AXES+k)*DATA_W +: DATA_W] = lane_res[k].vel;
      out_sat_d                                 = out_sat_d | lane_res[k].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      out_data_q <= out_data_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  // A read never meets a write-back to the same atom in the same cycle.
  a_no_read_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(mem_we && (atom_q[PIPE_STAGES] == in_atom)))
    else $error("read of an atom that is being written back");

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v_q[1])
    else $error("accepted request lost at the first stage");

  // A finished item held by a full output register stays in the last stage.
  a_last_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[PIPE_STAGES] && !ready_out) |=> v_q[PIPE_STAGES])
    else $error("item dropped from the last stage while stalled");

endmodule

`default_nettype wire

FILE: sv/vpi_lane.sv
// ----------------------------------------------------------------------------
// Verlet position integrator axis lane
// Four-stage datapath for one axis: magnitudes, products, rounding, sums
// with saturation. Stage loads come from the top-level flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module vpi_lane #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  vpi_pkg::lane_ctrl_t         ctrl_i,
  input  vpi_pkg::word_t              pos_i,
  input  vpi_pkg::word_t              vel_i,
  input  vpi_pkg::word_t              force_i,
  input  vpi_pkg::word_t              prev_i,
  input  vpi_pkg::word_t              ahead_i,
  input  logic [vpi_pkg::DATA_W-1:0]  time_step_i,
  input  logic [vpi_pkg::DATA_W-1:0]  time_step_sq_i,
  input  logic [vpi_pkg::DATA_W-1:0]  inv_two_steps_i,
  output vpi_pkg::lane_res_t          res_o
);

  import vpi_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned MAG_W  = PROD_W - FRACTION_BITS;
  localparam int unsigned TERM_W = MAG_W + 1;
  localparam int unsigned SUM_W  = TERM_W + 2;
  localparam logic [PROD_W-1:0] RND_F = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic [PROD_W-1:0] RND_H = PROD_W'(1) << FRACTION_BITS;

  // Operand magnitudes.
  logic signed [DATA_W:0] diff, bsel, bneg_full, aneg_full;
  logic                   bneg, aneg;
  logic [DATA_W-1:0]      bmag, amag;

  always_comb begin
    diff      = {ahead_i[DATA_W-1], ahead_i} - {prev_i[DATA_W-1], prev_i};
    bsel      = ctrl_i.step ? diff : {vel_i[DATA_W-1], vel_i};
    bneg      = bsel[DATA_W];
    bneg_full = -bsel;
    bmag      = bneg ? bneg_full[DATA_W-1:0] : bsel[DATA_W-1:0];
    aneg      = force_i[DATA_W-1];
    aneg_full = -{force_i[DATA_W-1], force_i};
    amag      = aneg ? aneg_full[DATA_W-1:0] : force_i;
  end

  logic              step2_q, aneg2_q, bneg2_q;
  word_t             pos2_q, vel2_q, ahead2_q;
  logic [DATA_W-1:0] amag2_q, bmag2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      step2_q  <= ctrl_i.step;
      pos2_q   <= pos_i;
      vel2_q   <= vel_i;
      ahead2_q <= ahead_i;
      aneg2_q  <= aneg;
      bneg2_q  <= bneg;
      amag2_q  <= amag;
      bmag2_q  <= bmag;
    end
  end

  // Products.
  logic [DATA_W-1:0] bmul;
  logic [PROD_W-1:0] prod_a, prod_b;

  assign bmul   = step2_q ? inv_two_steps_i : time_step_i;
  assign prod_a = amag2_q * time_step_sq_i;
  assign prod_b = bmag2_q * bmul;

  logic              step3_q, aneg3_q, bneg3_q;
  word_t             pos3_q, vel3_q, ahead3_q;
  logic [PROD_W-1:0] prod_a3_q, prod_b3_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      step3_q   <= step2_q;
      pos3_q    <= pos2_q;
      vel3_q    <= vel2_q;
      ahead3_q  <= ahead2_q;
      aneg3_q   <= aneg2_q;
      bneg3_q   <= bneg2_q;
      prod_a3_q <= prod_a;
      prod_b3_q <= prod_b;
    end
  end

  // Rounding to nearest, ties away from zero, on the magnitudes.
  logic [PROD_W-1:0]        acc_sh, half_sh, bt_sh;
  logic [MAG_W-1:0]         acc_mag, half_mag, bt_mag;
  logic signed [TERM_W-1:0] acc_t, half_t, bt_t;

  always_comb begin
    acc_sh   = (prod_a3_q + RND_F) >> FRACTION_BITS;
    half_sh  = (prod_a3_q + RND_H) >> (FRACTION_BITS + 1);
    bt_sh    = (prod_b3_q + RND_F) >> FRACTION_BITS;
    acc_mag  = acc_sh[MAG_W-1:0];
    half_mag = half_sh[MAG_W-1:0];
    bt_mag   = bt_sh[MAG_W-1:0];
    acc_t    = aneg3_q ? -$signed({1'b0, acc_mag})  : $signed({1'b0, acc_mag});
    half_t   = aneg3_q ? -$signed({1'b0, half_mag}) : $signed({1'b0, half_mag});
    bt_t     = bneg3_q ? -$signed({1'b0, bt_mag})   : $signed({1'b0, bt_mag});
  end

  logic                     step4_q;
  word_t                    pos4_q, vel4_q, ahead4_q;
  logic signed [TERM_W-1:0] acc4_q, half4_q, bt4_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      step4_q  <= step3_q;
      pos4_q   <= pos3_q;
      vel4_q   <= vel3_q;
      ahead4_q <= ahead3_q;
      acc4_q   <= acc_t;
      half4_q  <= half_t;
      bt4_q    <= bt_t;
    end
  end

  // Seed: previous position. Step: next ahead position and velocity.
  logic signed [SUM_W-1:0] seed_sum, step_sum, sum4;
  sat_t                    sat_a, sat_v;

  always_comb begin
    seed_sum = SUM_W'(pos4_q) - SUM_W'(bt4_q) + SUM_W'(half4_q);
    step_sum = (SUM_W'(ahead4_q) <<< 1) - SUM_W'(pos4_q) + SUM_W'(acc4_q);
    sum4     = step4_q ? step_sum : seed_sum;
    sat_a    = sat_word(SAT_IN_W'(sum4));
    sat_v    = sat_word(SAT_IN_W'(bt4_q));
  end

  logic                     step5_q, fa5_q, fv5_q;
  word_t                    pos5_q, vel5_q, ahead5_q, ra5_q, vc5_q;
  logic signed [TERM_W-1:0] acc5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      step5_q  <= step4_q;
      pos5_q   <= pos4_q;
      vel5_q   <= vel4_q;
      ahead5_q <= ahead4_q;
      acc5_q   <= acc4_q;
      ra5_q    <= sat_a.value;
      fa5_q    <= sat_a.flag;
      vc5_q    <= sat_v.value;
      fv5_q    <= sat_v.flag;
    end
  end

  // Seed: ahead position from the saturated previous position.
  logic signed [SUM_W-1:0] ahead_sum;
  sat_t                    sat_n;

  always_comb begin
    ahead_sum = (SUM_W'(pos5_q) <<< 1) - SUM_W'(ra5_q) + SUM_W'(acc5_q);
    sat_n     = sat_word(SAT_IN_W'(ahead_sum));
    res_o.pos      = step5_q ? ahead5_q : pos5_q;
    res_o.vel      = step5_q ? vc5_q : vel5_q;
    res_o.prev_wr  = step5_q ? pos5_q : ra5_q;
    res_o.ahead_wr = step5_q ? ra5_q : sat_n.value;
    res_o.sat      = step5_q ? (fa5_q | fv5_q) : (fa5_q | sat_n.flag);
  end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Verlet position integrator testbench
// Sends seed and step requests for atoms over the slave stream and checks
// every result against a built-in predictor of the per-atom position Verlet
// update. The predictor keeps its own copy of the stored positions and the
// step registers. Both streams pause at random, the registers are swept
// through their extremes between phases, and steps never reach an atom that
// has not been seeded.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import vpi_pkg::*;

  localparam int unsigned MAX_ATOMS     = 1024;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam longint      WORD_MAX      = 64'sd2147483647;
  localparam longint      WORD_MIN      = -64'sd2147483648;

  typedef word_t [NUM_AXES-1:0] axis_vec_t;

  typedef struct packed {
    axis_vec_t pos;
    axis_vec_t vel;
    logic      sat;
  } motion_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [DATA_W-1:0]      cfg_data_i;

  logic [DATA_W-1:0] step_dt    = TIME_STEP_RST;
  logic [DATA_W-1:0] step_dt_sq = TIME_STEP_SQ_RST;
  logic [DATA_W-1:0] inv_two_dt = INV_TWO_STEPS_RST;

  word_t   prev_store  [MAX_ATOMS][NUM_AXES];
  word_t   ahead_store [MAX_ATOMS][NUM_AXES];
  logic    seeded      [MAX_ATOMS];
  motion_t expected_motion [$];
  motion_t oldest;

  bit          steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned seeds_sent = 0;
  int unsigned steps_sent = 0;
  int unsigned clipped_results = 0;
  int unsigned register_writes = 0;
  string       axis_tag [NUM_AXES] = '{"x", "y", "z"};

  verlet_position_integrator #(
    .MAX_ATOMS    (MAX_ATOMS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 29);
  end

  // Product scaled down by 2^shift, rounded to nearest with ties away from zero.
  function automatic longint round_scaled(input longint x, input logic [DATA_W-1:0] c,
                                          input int unsigned shift);
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    mag  = (x < 0) ? -x : x;
    prod = mag * {32'd0, c};
    r    = (prod + (64'd1 << (shift - 1))) >> shift;
    return (x < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic word_t clip_word(input longint v, inout logic clipped);
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return word_t'(WORD_MAX);
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return word_t'(WORD_MIN);
    end
    return word_t'(v[DATA_W-1:0]);
  endfunction

  function automatic motion_t integrate_atom(input cmd_e cmd, input logic [ATOM_W-1:0] atom,
                                             input axis_vec_t pos, input axis_vec_t vel,
                                             input axis_vec_t accel);
    motion_t res;
    longint  q;
    longint  v;
    longint  a;
    longint  acc_term;
    longint  half_term;
    longint  ahd;
    longint  prv;
    word_t   prev_new;
    word_t   ahead_new;
    logic    clipped;
    clipped = 1'b0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      q        = longint'($signed(pos[ax]));
      v        = longint'($signed(vel[ax]));
      a        = longint'($signed(accel[ax]));
      acc_term = round_scaled(a, step_dt_sq, FRACTION_BITS);
      if (cmd == CMD_SEED) begin
        half_term   = round_scaled(a, step_dt_sq, FRACTION_BITS + 1);
        prev_new    = clip_word(q - round_scaled(v, step_dt, FRACTION_BITS) + half_term,
                                clipped);
        ahead_new   = clip_word(2 * q - longint'(prev_new) + acc_term, clipped);
        res.pos[ax] = pos[ax];
        res.vel[ax] = vel[ax];
      end else begin
        ahd         = longint'(ahead_store[atom][ax]);
        prv         = longint'(prev_store[atom][ax]);
        res.vel[ax] = clip_word(round_scaled(ahd - prv, inv_two_dt, FRACTION_BITS), clipped);
        ahead_new   = clip_word(2 * ahd - q + acc_term, clipped);
        prev_new    = pos[ax];
        res.pos[ax] = ahead_store[atom][ax];
      end
      prev_store[atom][ax]  = prev_new;
      ahead_store[atom][ax] = ahead_new;
    end
    res.sat = clipped;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_motion.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        oldest = expected_motion.pop_front();
        for (int ax = 0; ax < NUM_AXES; ax++) begin
          if (m_axis_tdata[ax*DATA_W +: DATA_W] !== oldest.pos[ax]) begin
            $error("new_position_%s: expected %0d, got %0d", axis_tag[ax],
                   oldest.pos[ax], $signed(m_axis_tdata[ax*DATA_W +: DATA_W]));
            mismatches++;
          end
          if (m_axis_tdata[(NUM_AXES+ax)*DATA_W +: DATA_W] !== oldest.vel[ax]) begin
            $error("new_velocity_%s: expected %0d, got %0d", axis_tag[ax],
                   oldest.vel[ax], $signed(m_axis_tdata[(NUM_AXES+ax)*DATA_W +: DATA_W]));
            mismatches++;
          end
        end
        if (m_axis_tuser !== oldest.sat) begin
          $error("saturated: expected %0d, got %0d", oldest.sat, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(input cmd_e cmd, input logic [ATOM_W-1:0] atom,
                              input axis_vec_t pos, input axis_vec_t vel,
                              input axis_vec_t accel);
    int unsigned           gap;
    logic [IN_TDATA_W-1:0] packed_req;
    motion_t               res;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < 29 && gap < 12) gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    packed_req = '0;
    packed_req[ATOM_W+9*DATA_W-1:0] = {accel, vel, pos, atom};
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= packed_req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = integrate_atom(cmd, atom, pos, vel, accel);
    expected_motion.push_back(res);
    seeded[atom] = 1'b1;
    if (cmd == CMD_SEED) seeds_sent++;
    else steps_sent++;
    if (res.sat) clipped_results++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_motion.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_STAGES + 3) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [DATA_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TIME_STEP:     step_dt    = value;
      CFG_TIME_STEP_SQ:  step_dt_sq = value;
      CFG_INV_TWO_STEPS: inv_two_dt = value;
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic set_step_registers(input logic [DATA_W-1:0] dt, input logic [DATA_W-1:0] dt_sq,
                                    input logic [DATA_W-1:0] inv_two);
    write_register(CFG_TIME_STEP, dt);
    write_register(CFG_TIME_STEP_SQ, dt_sq);
    write_register(CFG_INV_TWO_STEPS, inv_two);
  endtask

  function automatic word_t random_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return word_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    if (pick < 8) return word_t'($urandom);
    if (pick == 8) return word_t'(WORD_MAX);
    return word_t'(WORD_MIN);
  endfunction

  task automatic send_random_item();
    logic [ATOM_W-1:0] atom;
    cmd_e              cmd;
    axis_vec_t         pos;
    axis_vec_t         vel;
    axis_vec_t         accel;
    if ($urandom_range(0, 99) < 50) atom = ATOM_W'($urandom_range(3, 6));
    else atom = ATOM_W'($urandom);
    if (!seeded[atom] || $urandom_range(0, 99) < 20) cmd = CMD_SEED;
    else cmd = CMD_STEP;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      pos[ax]   = random_word();
      vel[ax]   = random_word();
      accel[ax] = random_word();
    end
    send_request(cmd, atom, pos, vel, accel);
  endtask

  task automatic test_single_atom();
    send_request(CMD_SEED, 10'd5, {32'sh0003_0000, -32'sh0001_8000, 32'sh0000_4000},
                 {32'sh0000_2000, 32'sh0001_0000, -32'sh0000_0100},
                 {-32'sh0002_0000, 32'sh0000_0800, 32'sh0010_0000});
    for (int i = 0; i < 3; i++) begin
      send_request(CMD_STEP, 10'd5, {32'sh0003_1000, -32'sh0001_7000, 32'sh0000_4200},
                   '0, {-32'sh0001_0000, 32'sh0000_0400, 32'sh0008_0000});
    end
    drain_results();
  endtask

  task automatic test_atom_index_extremes();
    send_request(CMD_SEED, 10'd0, {3{32'sh0000_1234}}, {3{-32'sh0000_0042}}, {3{32'sh0000_0777}});
    send_request(CMD_SEED, 10'd1023, {3{-32'sh0123_4567}}, {3{32'sh0000_9999}}, {3{-32'sh55}});
    send_request(CMD_STEP, 10'd0, {3{32'sh0000_1200}}, {3{32'sh7fff_ffff}}, {3{32'sh0000_0100}});
    send_request(CMD_STEP, 10'd1023, {3{-32'sh0123_0000}}, {3{-32'sh1}}, {3{-32'sh0000_0100}});
    drain_results();
  endtask

  // Seed velocity and half terms and step acceleration terms each land on a half.
  task automatic test_rounding_ties();
    send_request(CMD_SEED, 10'd7, {32'sh0001_0000, -32'sh0001_0000, 32'sh0},
                 {32'sh0000_8000, -32'sh0000_8000, 32'sh0000_8000},
                 {32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000});
    send_request(CMD_STEP, 10'd7, {32'sh0001_0001, -32'sh0000_ffff, 32'sh1},
                 '0, {32'sh0000_8000, -32'sh0000_8000, 32'sh0000_8000});
    send_request(CMD_STEP, 10'd7, {32'sh0001_0003, -32'sh0000_fffd, -32'sh1},
                 '0, {-32'sh0000_8000, 32'sh0000_8000, -32'sh0000_8000});
    drain_results();
  endtask

  task automatic test_saturation();
    send_request(CMD_SEED, 10'd9, {3{32'sh7fff_ffff}}, {3{32'sh8000_0000}}, {3{32'sh7fff_ffff}});
    send_request(CMD_SEED, 10'd10, {3{32'sh8000_0000}}, {3{32'sh7fff_ffff}}, {3{32'sh8000_0000}});
    send_request(CMD_STEP, 10'd9, {3{32'sh8000_0000}}, '0, {3{32'sh7fff_ffff}});
    send_request(CMD_STEP, 10'd10, {3{32'sh7fff_ffff}}, '0, {3{32'sh8000_0000}});
    send_request(CMD_STEP, 10'd9, {3{32'sh7fff_ffff}}, '0, {3{32'sh8000_0000}});
    drain_results();
  endtask

  task automatic test_back_to_back_atoms();
    steady = 1'b1;
    send_request(CMD_SEED, 10'd20, {3{32'sh0002_0000}}, {3{32'sh0000_1000}}, {3{32'sh0000_0400}});
    send_request(CMD_STEP, 10'd20, {3{32'sh0002_0100}}, '0, {3{-32'sh0000_0400}});
    send_request(CMD_STEP, 10'd20, {3{32'sh0002_0180}}, '0, {3{32'sh0000_0200}});
    send_request(CMD_SEED, 10'd21, {3{-32'sh0004_0000}}, {3{32'sh0000_3000}}, {3{32'sh0}});
    send_request(CMD_STEP, 10'd21, {3{-32'sh0003_ff00}}, '0, {3{32'sh0001_0000}});
    drain_results();
    steady = 1'b0;
  endtask

  task automatic test_register_extremes();
    set_step_registers(32'h0, 32'h0, 32'h0);
    repeat (30) send_random_item();
    set_step_registers(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    repeat (30) send_random_item();
    set_step_registers(32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
    repeat (30) send_random_item();
    set_step_registers(TIME_STEP_RST, TIME_STEP_SQ_RST, INV_TWO_STEPS_RST);
    repeat (30) send_random_item();
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [63:0] dt;
    for (int i = 0; i < 280; i++) begin
      if (i % 100 == 0 && i != 0) begin
        if ($urandom_range(0, 1) == 0) begin
          dt = 64'($urandom_range(1, 32'h0001_0000));
          set_step_registers(dt[31:0], 32'((dt * dt + 64'h8000) >> 16),
                             32'((64'h1_0000_0000 / dt) >> 1));
        end else begin
          set_step_registers($urandom, $urandom, $urandom);
        end
      end
      steady = (i >= 150 && i < 250);
      send_random_item();
    end
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < MAX_ATOMS; i++) seeded[i] = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_SEED;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_TIME_STEP;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_atom();
    test_atom_index_extremes();
    test_rounding_ties();
    test_saturation();
    test_back_to_back_atoms();
    test_register_extremes();
    test_random_traffic();

    drain_results();
    if (expected_motion.size() != 0) begin
      $error("%0d results never arrived", expected_motion.size());
      mismatches++;
    end
    $display("Ran %0d seed and %0d step requests across %0d register writes.",
             seeds_sent, steps_sent, register_writes);
    $display("%0d results were clipped; %0d mismatches found.", clipped_results, mismatches);
    if (mismatches == 0) begin
      $display("verlet_position_integrator verification clean");
    end else begin
      $display("verlet_position_integrator verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("verlet_position_integrator verification failed");
    $finish;
  end

endmodule
